[hdl/hc_pkg.sv]
package hc_pkg;

   localparam int unsigned CHAR_IN_W  = 8;
   localparam int unsigned CHAR_OUT_W = 7;
   localparam int unsigned LETTER_W   = 5;
   localparam int unsigned KEY_W      = 5;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned SUM_W      = 11;
   localparam int unsigned QUO_W      = 6;
   localparam int unsigned RECIP_W    = 12;
   localparam int unsigned PROD_W     = SUM_W + RECIP_W;
   localparam int unsigned RECIP_SH   = 16;

   localparam logic [CHAR_IN_W-1:0]  ASCII_A_IN  = 8'd65;
   localparam logic [CHAR_IN_W-1:0]  ASCII_Z_IN  = 8'd90;
   localparam logic [CHAR_OUT_W-1:0] ASCII_A_OUT = 7'd65;
   localparam logic [SUM_W-1:0]      ALPHA       = 11'd26;
   localparam logic [RECIP_W-1:0]    RECIP       = 12'd2521;

   localparam logic [KEY_W-1:0] KEY_A_RST = 5'd1;
   localparam logic [KEY_W-1:0] KEY_B_RST = 5'd2;
   localparam logic [KEY_W-1:0] KEY_C_RST = 5'd3;
   localparam logic [KEY_W-1:0] KEY_D_RST = 5'd5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY_A = 2'd0,
      CSR_KEY_B = 2'd1,
      CSR_KEY_C = 2'd2,
      CSR_KEY_D = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [KEY_W-1:0] ka;
      logic [KEY_W-1:0] kb;
      logic [KEY_W-1:0] kc;
      logic [KEY_W-1:0] kd;
   } key_type;

   typedef struct packed {
      logic [LETTER_W-1:0] p0;
      logic [LETTER_W-1:0] p1;
      logic                single;
      logic                last;
   } job_type;

   function automatic logic [LETTER_W-1:0] letter_value(input logic [CHAR_IN_W-1:0] b);
      logic [CHAR_IN_W-1:0] d;
      d = b - ASCII_A_IN;
      if (b >= ASCII_A_IN && b <= ASCII_Z_IN) begin
         return d[LETTER_W-1:0];
      end
      return '0;
   endfunction

endpackage

[hdl/hc_if.sv]
interface hc_req_if;
   logic                           valid;
   logic                           ready;
   logic [hc_pkg::CHAR_IN_W-1:0]   char_in;
   logic                           msg_end;

   modport source (output valid, output char_in, output msg_end, input ready);
   modport sink (input valid, input char_in, input msg_end, output ready);
endinterface

interface hc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [hc_pkg::CHAR_OUT_W-1:0]  char_out;
   logic                           out_last;

   modport source (output valid, output char_out, output out_last, input ready);
   modport sink (input valid, input char_out, input out_last, output ready);
endinterface

[hdl/hill_cipher_2x2_letters.sv]
// A completed pair is pushed into the job queue as one job, which then passes the stage
// registers s1, s2 and s3; its second letter is offered once the first is taken.
// Throughput: one item per cycle, set by the single result register that hands out one
// letter per cycle unless stalled; a four-entry job queue splits input from arithmetic.
// Reset is synchronous and active high; it clears the held letter, the queue and the
// pipeline, and loads the key registers with 1, 2, 3 and 5.
module hill_cipher_2x2_letters #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   hc_req_if.sink                    req_ch,
   hc_rsp_if.source                  rsp_ch,
   input  logic                      csr_we,
   input  logic [hc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [hc_pkg::KEY_W-1:0]  csr_wdata
);
   import hc_pkg::*;

   key_type keys_ff, keys_in;
   logic    push, q_full, head_valid, pop;
   job_type job, head;

   always_comb begin
      keys_in = keys_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_KEY_A: keys_in.ka = csr_wdata;
            CSR_KEY_B: keys_in.kb = csr_wdata;
            CSR_KEY_C: keys_in.kc = csr_wdata;
            CSR_KEY_D: keys_in.kd = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keys_ff <= '{ka: KEY_A_RST, kb: KEY_B_RST, kc: KEY_C_RST, kd: KEY_D_RST};
      end else begin
         keys_ff <= keys_in;
      end
   end

   hc_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_full (q_full),
      .push   (push),
      .job    (job)
   );

   hc_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .wr_job    (job),
      .pop       (pop),
      .full      (q_full),
      .not_empty (head_valid),
      .head      (head)
   );

   hc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .keys       (keys_ff),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

[hdl/hc_front.sv]
module hc_front (
   input  logic            clock,
   input  logic            reset,
   hc_req_if.sink          req_ch,
   input  logic            q_full,
   output logic            push,
   output hc_pkg::job_type job
);
   import hc_pkg::*;

   logic                have_held_ff, have_held_in;
   logic [LETTER_W-1:0] held_ff, held_in;
   logic                take;
   logic [LETTER_W-1:0] p;

   assign req_ch.ready = !q_full;
   assign take         = req_ch.valid && !q_full;
   assign p            = letter_value(req_ch.char_in);

   always_comb begin
      have_held_in = have_held_ff;
      held_in      = held_ff;
      push         = 1'b0;
      job          = '{p0: held_ff, p1: p, single: 1'b0, last: req_ch.msg_end};
      if (take) begin
         if (have_held_ff) begin
            push         = 1'b1;
            have_held_in = 1'b0;
            held_in      = '0;
         end else if (req_ch.msg_end) begin
            push = 1'b1;
            job  = '{p0: p, p1: '0, single: 1'b1, last: 1'b1};
         end else begin
            have_held_in = 1'b1;
            held_in      = p;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_held_ff <= 1'b0;
         held_ff      <= '0;
      end else begin
         have_held_ff <= have_held_in;
         held_ff      <= held_in;
      end
   end

endmodule

[hdl/hc_fifo.sv]
module hc_fifo #(
   parameter int unsigned DEPTH = 4
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  hc_pkg::job_type wr_job,
   input  logic            pop,
   output logic            full,
   output logic            not_empty,
   output hc_pkg::job_type head
);
   import hc_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   job_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == FULL_CNT);
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_job;
      end
   end

endmodule

[hdl/hc_back.sv]
module hc_back (
   input  logic            clock,
   input  logic            reset,
   input  hc_pkg::key_type keys,
   input  logic            head_valid,
   input  hc_pkg::job_type head,
   output logic            pop,
   hc_rsp_if.source        rsp_ch
);
   import hc_pkg::*;

   logic               s1_valid_ff, s1_valid_in;
   logic [SUM_W-1:0]   s1_sum0_ff, s1_sum1_ff;
   logic               s1_single_ff, s1_last_ff;

   logic               s2_valid_ff, s2_valid_in;
   logic [SUM_W-1:0]   s2_sum0_ff, s2_sum1_ff;
   logic [QUO_W-1:0]   s2_quo0_ff, s2_quo1_ff;
   logic               s2_single_ff, s2_last_ff;

   logic                s3_valid_ff, s3_valid_in;
   logic                s3_second_ff, s3_second_in;
   logic [LETTER_W-1:0] s3_let0_ff, s3_let1_ff;
   logic                s3_single_ff, s3_last_ff;

   logic [SUM_W-1:0]  sum0, sum1;
   logic [PROD_W-1:0] prod0, prod1;
   logic [SUM_W-1:0]  rem0, rem1;
   logic              take, final_letter, adv;

   assign sum0 = SUM_W'(keys.ka) * SUM_W'(head.p0) + SUM_W'(keys.kb) * SUM_W'(head.p1);
   assign sum1 = SUM_W'(keys.kc) * SUM_W'(head.p0) + SUM_W'(keys.kd) * SUM_W'(head.p1);

   assign prod0 = PROD_W'(s1_sum0_ff) * PROD_W'(RECIP);
   assign prod1 = PROD_W'(s1_sum1_ff) * PROD_W'(RECIP);

   assign rem0 = s2_sum0_ff - SUM_W'(s2_quo0_ff) * ALPHA;
   assign rem1 = s2_sum1_ff - SUM_W'(s2_quo1_ff) * ALPHA;

   assign take         = s3_valid_ff && rsp_ch.ready;
   assign final_letter = s3_single_ff || s3_second_ff;
   assign adv          = !s3_valid_ff || (take && final_letter);
   assign pop          = adv && head_valid;

   assign s1_valid_in  = adv ? head_valid : s1_valid_ff;
   assign s2_valid_in  = adv ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in  = adv ? s2_valid_ff : s3_valid_ff;
   assign s3_second_in = adv ? 1'b0 : (s3_second_ff || take);

   assign rsp_ch.valid    = s3_valid_ff;
   assign rsp_ch.char_out = ASCII_A_OUT + CHAR_OUT_W'(s3_second_ff ? s3_let1_ff : s3_let0_ff);
   assign rsp_ch.out_last = s3_second_ff ? s3_last_ff : (s3_single_ff && s3_last_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s3_second_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         s3_second_ff <= s3_second_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_sum0_ff   <= sum0;
         s1_sum1_ff   <= sum1;
         s1_single_ff <= head.single;
         s1_last_ff   <= head.last;
         s2_sum0_ff   <= s1_sum0_ff;
         s2_sum1_ff   <= s1_sum1_ff;
         s2_quo0_ff   <= prod0[RECIP_SH +: QUO_W];
         s2_quo1_ff   <= prod1[RECIP_SH +: QUO_W];
         s2_single_ff <= s1_single_ff;
         s2_last_ff   <= s1_last_ff;
         s3_let0_ff   <= rem0[LETTER_W-1:0];
         s3_let1_ff   <= rem1[LETTER_W-1:0];
         s3_single_ff <= s2_single_ff;
         s3_last_ff   <= s2_last_ff;
      end
   end

endmodule

[hdl/hc_checker.sv]
module hc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [6:0] char_out,
   input logic       out_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(char_out) && $stable(out_last))
      else $error("result item changed while stalled");

   a_letter_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (char_out >= 7'd65) && (char_out <= 7'd90))
      else $error("result item is not an uppercase letter");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item offered right after reset");

endmodule

bind hill_cipher_2x2_letters hc_checker u_hc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .char_out  (rsp_ch.char_out),
   .out_last  (rsp_ch.out_last)
);

[test/hill_cipher_2x2_letters_test.sv]
module hill_cipher_2x2_letters_test;
   timeunit 1ns;
   timeprecision 1ps;

   import hc_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [CHAR_OUT_W-1:0] char_out;
      logic                  out_last;
   } letter_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   csr_index_type        csr_index;
   logic [KEY_W-1:0]     csr_wdata;

   hc_req_if req_ch ();
   hc_rsp_if rsp_ch ();

   hill_cipher_2x2_letters u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the key and of the pair state.
   logic [KEY_W-1:0]    key_m00, key_m01, key_m10, key_m11;
   logic [LETTER_W-1:0] pending_letter;
   logic                pending_valid;

   letter_type expected_letters[$];
   int unsigned fail_count;
   int unsigned cycle_count;
   bit          tx_gaps_on;
   bit          rx_gaps_on;
   int unsigned rx_hold_request;

   initial begin
      clock = 1'b0;
   end

   always begin
      #4 clock = ~clock;
   end

   function automatic logic [LETTER_W-1:0] byte_to_letter(input logic [CHAR_IN_W-1:0] b);
      if (b >= 8'd65 && b <= 8'd90) begin
         return LETTER_W'(b - 8'd65);
      end
      return '0;
   endfunction

   function automatic logic [CHAR_OUT_W-1:0] cipher_letter(input logic [KEY_W-1:0] k0,
                                                          input logic [KEY_W-1:0] k1,
                                                          input logic [LETTER_W-1:0] p0,
                                                          input logic [LETTER_W-1:0] p1);
      int unsigned total;
      total = k0 * p0 + k1 * p1;
      return CHAR_OUT_W'(65 + (total % 26));
   endfunction

   function automatic void queue_letter(input letter_type r);
      expected_letters = {expected_letters, r};
   endfunction

   task automatic encipher_item(input logic [CHAR_IN_W-1:0] c, input logic e);
      logic [LETTER_W-1:0] p;
      letter_type          r;
      p = byte_to_letter(c);
      if (!pending_valid) begin
         if (e) begin
            r.char_out = cipher_letter(key_m00, key_m01, p, '0);
            r.out_last = 1'b1;
            queue_letter(r);
         end else begin
            pending_letter = p;
            pending_valid  = 1'b1;
         end
      end else begin
         r.char_out = cipher_letter(key_m00, key_m01, pending_letter, p);
         r.out_last = 1'b0;
         queue_letter(r);
         r.char_out = cipher_letter(key_m10, key_m11, pending_letter, p);
         r.out_last = e;
         queue_letter(r);
         pending_valid  = 1'b0;
         pending_letter = '0;
      end
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_char(input logic [CHAR_IN_W-1:0] c, input logic e);
      while (tx_gaps_on && $urandom_range(99) < 17) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.char_in <= c;
      req_ch.msg_end <= e;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      encipher_item(c, e);
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_char(s[i], i == s.len() - 1);
      end
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (expected_letters.size() != 0) begin
         @(negedge clock);
      end
      repeat (10) @(negedge clock);
   endtask

   task automatic put_key(input csr_index_type idx, input logic [KEY_W-1:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      case (idx)
         CSR_KEY_A: key_m00 = v;
         CSR_KEY_B: key_m01 = v;
         CSR_KEY_C: key_m10 = v;
         CSR_KEY_D: key_m11 = v;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic load_key(input logic [KEY_W-1:0] ka, input logic [KEY_W-1:0] kb,
                           input logic [KEY_W-1:0] kc, input logic [KEY_W-1:0] kd);
      wait_drained();
      put_key(CSR_KEY_A, ka);
      put_key(CSR_KEY_B, kb);
      put_key(CSR_KEY_C, kc);
      put_key(CSR_KEY_D, kd);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [CHAR_IN_W-1:0] random_char();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 70) begin
         return CHAR_IN_W'(65 + $urandom_range(25));
      end else if (pick < 90) begin
         return CHAR_IN_W'($urandom_range(255));
      end
      case ($urandom_range(3))
         0: return 8'd65;
         1: return 8'd90;
         2: return 8'h00;
         default: return 8'hFF;
      endcase
   endfunction

   task automatic test_reset_key();
      send_text("HELP");
      send_text("Z");
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b0);
      send_char(8'd64, 1'b0);
      send_char(8'd91, 1'b0);
      send_char("a", 1'b0);
      send_char("z", 1'b0);
      send_char("A", 1'b0);
      send_char("Z", 1'b1);
      send_text("ZZZ");
   endtask

   task automatic test_key_extremes();
      load_key(5'd0, 5'd0, 5'd0, 5'd0);
      send_text("ZYX");
      load_key(5'd25, 5'd25, 5'd25, 5'd25);
      send_text("ZZAZ");
      load_key(5'd31, 5'd31, 5'd31, 5'd31);
      send_text("ZZY");
      load_key(5'd26, 5'd0, 5'd31, 5'd1);
      send_text("QZ");
   endtask

   task automatic test_decrypt();
      load_key(5'd21, 5'd2, 5'd3, 5'd25);
      // HELP enciphered with the reset key.
      send_text("PPPE");
   endtask

   task automatic test_backpressure();
      bit saved_tx;
      saved_tx = tx_gaps_on;
      wait_drained();
      tx_gaps_on = 1'b0;
      rx_hold_request = 300;
      for (int i = 0; i < 60; i++) begin
         send_char(random_char(), i == 59);
      end
      tx_gaps_on = saved_tx;
   endtask

   task automatic test_random(input int unsigned n_items);
      int unsigned sent;
      int unsigned msg_len;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(9) == 0) begin
            load_key(KEY_W'($urandom_range(31)), KEY_W'($urandom_range(31)),
                     KEY_W'($urandom_range(31)), KEY_W'($urandom_range(31)));
         end
         msg_len = $urandom_range(1, 14);
         for (int i = 0; i < msg_len; i++) begin
            send_char(random_char(), i == msg_len - 1);
         end
         sent += msg_len;
      end
   endtask

   always @(negedge clock) begin
      int unsigned hold_left;
      if (rx_hold_request != 0) begin
         hold_left = rx_hold_request;
         rx_hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (rx_gaps_on && $urandom_range(99) < 17) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      letter_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_letters.size() == 0) begin
            $display("%0t: unexpected letter char_out=%0d out_last=%0b", $time,
                     rsp_ch.char_out, rsp_ch.out_last);
            fail_count++;
         end else begin
            want = expected_letters.pop_front();
            if (rsp_ch.char_out !== want.char_out) begin
               $display("%0t: char_out expected %0d actual %0d", $time, want.char_out,
                        rsp_ch.char_out);
               fail_count++;
            end
            if (rsp_ch.out_last !== want.out_last) begin
               $display("%0t: out_last expected %0b actual %0b", $time, want.out_last,
                        rsp_ch.out_last);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** hill_cipher_2x2_letters: FAILED **");
         $finish;
      end
   end

   initial begin
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = CSR_KEY_A;
      csr_wdata       = '0;
      req_ch.valid    = 1'b0;
      req_ch.char_in  = '0;
      req_ch.msg_end  = 1'b0;
      rsp_ch.ready    = 1'b0;
      fail_count      = 0;
      cycle_count     = 0;
      rx_hold_request = 0;
      tx_gaps_on      = 1'b1;
      rx_gaps_on      = 1'b1;
      key_m00         = KEY_A_RST;
      key_m01         = KEY_B_RST;
      key_m10         = KEY_C_RST;
      key_m11         = KEY_D_RST;
      pending_letter  = '0;
      pending_valid   = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_key();
      test_key_extremes();
      test_decrypt();
      load_key(5'd3, 5'd3, 5'd2, 5'd5);
      test_random(500);
      test_backpressure();
      tx_gaps_on = 1'b0;
      rx_gaps_on = 1'b0;
      test_random(300);
      tx_gaps_on = 1'b1;
      rx_gaps_on = 1'b1;
      test_random(600);

      wait_drained();
      repeat (20) @(negedge clock);
      if (fail_count == 0) begin
         $display("** hill_cipher_2x2_letters: PASSED **");
      end else begin
         $display("** hill_cipher_2x2_letters: FAILED **");
      end
      $finish;
   end

endmodule
